### hw/rtl/tpdss_pkg.sv
// ----------------------------------------------------------------------------
// tpdss_pkg: shared types and constants of the three-phase DDS sine core
// Widths, phase offsets, register codes, the queue command type and the
// quarter-wave sine table.
// ----------------------------------------------------------------------------
package tpdss_pkg;

  // Phase accumulator and quarter-wave table geometry.
  localparam int PHASE_BITS  = 32;
  localparam int SEG_BITS    = 6;
  localparam int FRAC_BITS   = PHASE_BITS - 2 - SEG_BITS;
  localparam int IDX_W       = SEG_BITS + 1;
  localparam int SINE_MAG_W  = 15;

  // Field widths of the result beat.
  localparam int SINE_W      = 16;
  localparam int VOLT_W      = 17;
  localparam int RAMP_W      = 17;
  localparam int MOD_W       = 17;
  localparam int PHASE_NOW_W = 32;
  localparam int OUT_FIELDS_W = 3 * SINE_W + 3 * VOLT_W + RAMP_W + MOD_W + PHASE_NOW_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int IN_TDATA_W   = 8;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_INC  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PEAK_AMP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAMP_STEP  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MOD_TARGET = 2'd3;

  localparam logic [31:0]       PHASE_INC_RST  = 32'd25769804;
  localparam logic [15:0]       PEAK_AMP_RST   = 16'd0;
  localparam logic [RAMP_W-1:0] RAMP_STEP_RST  = 17'd7;
  localparam logic [MOD_W-1:0]  MOD_TARGET_RST = 17'd0;

  // Phase offsets of 120 and 240 degrees, rounded.
  localparam logic [PHASE_BITS-1:0] OFF120 =
    PHASE_BITS'(((64'd1 << PHASE_BITS) + 64'd1) / 64'd3);
  localparam logic [PHASE_BITS-1:0] OFF240 =
    PHASE_BITS'(((64'd1 << (PHASE_BITS + 1)) + 64'd1) / 64'd3);

  // Unity in Q1.16.
  localparam logic [RAMP_W-1:0] RAMP_FULL = 17'h10000;

  // Shared multiplier: the A side holds the 32-bit amplitude product.
  localparam int MUL_A_W  = 32;
  localparam int MUL_B_W  = (FRAC_BITS > RAMP_W) ? FRAC_BITS : RAMP_W;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int VOLT_SHIFT = 31;
  localparam int MOD_SHIFT  = 16;

  // Front-to-back command queue.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_TICK    = 1'b0,
    KIND_RESTART = 1'b1
  } kind_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic [31:0]       phase_increment;
    logic [15:0]       peak_amplitude;
    logic [RAMP_W-1:0] ramp_step;
    logic [MOD_W-1:0]  modulation_target;
  } cfg_t;

  // Quarter-wave table: round(32768 * sin(k * 90 deg / 64)), top entry capped.
  function automatic logic [SINE_MAG_W-1:0] sine_rom(input logic [IDX_W-1:0] k);
    unique case (k)
      7'd0:  sine_rom = 15'd0;
      7'd1:  sine_rom = 15'd804;
      7'd2:  sine_rom = 15'd1608;
      7'd3:  sine_rom = 15'd2411;
      7'd4:  sine_rom = 15'd3212;
      7'd5:  sine_rom = 15'd4011;
      7'd6:  sine_rom = 15'd4808;
      7'd7:  sine_rom = 15'd5602;
      7'd8:  sine_rom = 15'd6393;
      7'd9:  sine_rom = 15'd7180;
      7'd10: sine_rom = 15'd7962;
      7'd11: sine_rom = 15'd8740;
      7'd12: sine_rom = 15'd9512;
      7'd13: sine_rom = 15'd10279;
      7'd14: sine_rom = 15'd11039;
      7'd15: sine_rom = 15'd11793;
      7'd16: sine_rom = 15'd12540;
      7'd17: sine_rom = 15'd13279;
      7'd18: sine_rom = 15'd14010;
      7'd19: sine_rom = 15'd14733;
      7'd20: sine_rom = 15'd15447;
      7'd21: sine_rom = 15'd16151;
      7'd22: sine_rom = 15'd16846;
      7'd23: sine_rom = 15'd17531;
      7'd24: sine_rom = 15'd18205;
      7'd25: sine_rom = 15'd18868;
      7'd26: sine_rom = 15'd19520;
      7'd27: sine_rom = 15'd20160;
      7'd28: sine_rom = 15'd20788;
      7'd29: sine_rom = 15'd21403;
      7'd30: sine_rom = 15'd22006;
      7'd31: sine_rom = 15'd22595;
      7'd32: sine_rom = 15'd23170;
      7'd33: sine_rom = 15'd23732;
      7'd34: sine_rom = 15'd24279;
      7'd35: sine_rom = 15'd24812;
      7'd36: sine_rom = 15'd25330;
      7'd37: sine_rom = 15'd25833;
      7'd38: sine_rom = 15'd26320;
      7'd39: sine_rom = 15'd26791;
      7'd40: sine_rom = 15'd27246;
      7'd41: sine_rom = 15'd27684;
      7'd42: sine_rom = 15'd28106;
      7'd43: sine_rom = 15'd28511;
      7'd44: sine_rom = 15'd28899;
      7'd45: sine_rom = 15'd29269;
      7'd46: sine_rom = 15'd29622;
      7'd47: sine_rom = 15'd29957;
      7'd48: sine_rom = 15'd30274;
      7'd49: sine_rom = 15'd30572;
      7'd50: sine_rom = 15'd30853;
      7'd51: sine_rom = 15'd31114;
      7'd52: sine_rom = 15'd31357;
      7'd53: sine_rom = 15'd31581;
      7'd54: sine_rom = 15'd31786;
      7'd55: sine_rom = 15'd31972;
      7'd56: sine_rom = 15'd32138;
      7'd57: sine_rom = 15'd32286;
      7'd58: sine_rom = 15'd32413;
      7'd59: sine_rom = 15'd32522;
      7'd60: sine_rom = 15'd32610;
      7'd61: sine_rom = 15'd32679;
      7'd62: sine_rom = 15'd32729;
      7'd63: sine_rom = 15'd32758;
      7'd64: sine_rom = 15'd32767;
      default: sine_rom = '0;
    endcase
  endfunction

endpackage

### hw/rtl/tpdss_front.sv
// ----------------------------------------------------------------------------
// tpdss_front: input acceptance and command queue
// Takes input beats, classifies each as a tick or a restart and holds them
// in a short queue for the execution sequencer.
// ----------------------------------------------------------------------------
module tpdss_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tpdss_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                              pop,
  output tpdss_pkg::cmd_t                   cmd
);
  import tpdss_pkg::*;

  kind_t             q_r   [0:QUEUE_DEPTH-1];
  kind_t             q_nxt [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push;
  kind_t             kind_in;

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign kind_in   = in_tdata[0] ? KIND_RESTART : KIND_TICK;

  assign cmd.valid = (count_r != '0);
  assign cmd.kind  = q_r[rd_ptr_r];

  always_comb begin
    q_nxt      = q_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      q_nxt[wr_ptr_r] = kind_in;
      wr_ptr_nxt      = wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + QPTR_W'(1);
    end
    count_nxt = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

### hw/rtl/tpdss_back.sv
// ----------------------------------------------------------------------------
// tpdss_back: tick execution sequencer
// Owns the phase and soft-start state, runs the three table lookups and all
// products through one shared multiplier, and holds the result beat.
// ----------------------------------------------------------------------------
module tpdss_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tpdss_pkg::cfg_t                   cfg,
  input  tpdss_pkg::cmd_t                   cmd,
  output logic                              pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tpdss_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tpdss_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_AMP  = 4'd1;
  localparam logic [3:0] ST_MOD  = 4'd2;
  localparam logic [3:0] ST_LOOK = 4'd3;
  localparam logic [3:0] ST_INTP = 4'd4;
  localparam logic [3:0] ST_SINE = 4'd5;
  localparam logic [3:0] ST_VOLT = 4'd6;
  localparam logic [3:0] ST_VSTR = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  localparam logic [1:0] LANE_FIRST = 2'd0;
  localparam logic [1:0] LANE_LAST  = 2'd2;

  localparam logic [PHASE_BITS-1:0] HALF_P    = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [PHASE_BITS-2:0] QUARTER_H = {1'b1, {(PHASE_BITS-2){1'b0}}};

  // Control state.
  logic [3:0]            state_r, state_nxt;
  logic [1:0]            lane_r, lane_nxt;
  logic [PHASE_BITS-1:0] phase_acc_r, phase_acc_nxt;
  logic [RAMP_W-1:0]     ramp_acc_r, ramp_acc_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Working registers.
  logic [MUL_A_W-1:0]    amp_r, amp_nxt;
  logic [MOD_W-1:0]      mod_r, mod_nxt;
  logic [PHASE_BITS-1:0] ph_r   [0:2];
  logic [PHASE_BITS-1:0] ph_nxt [0:2];
  logic [SINE_MAG_W-1:0] lo_r, lo_nxt;
  logic [SINE_MAG_W-1:0] hi_r, hi_nxt;
  logic [FRAC_BITS-1:0]  frac_r, frac_nxt;
  logic                  neg_r, neg_nxt;
  logic [SINE_MAG_W-1:0] mag_r, mag_nxt;
  logic [SINE_W-1:0]     sine_r   [0:2];
  logic [SINE_W-1:0]     sine_nxt [0:2];
  logic [VOLT_W-1:0]     volt_r   [0:2];
  logic [VOLT_W-1:0]     volt_nxt [0:2];
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Shared multiplier operands.
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;

  // Datapath helpers.
  logic [RAMP_W:0]       ramp_sum;
  logic [RAMP_W-1:0]     ramp_stepped;
  logic [PHASE_BITS-1:0] ph_sel;
  logic [PHASE_BITS-2:0] half_mag;
  logic [PHASE_BITS-1:0] refl;
  logic [PHASE_BITS-2:0] folded;
  logic [IDX_W-1:0]      idx;
  logic [PROD_W-1:0]     msum;
  logic [MOD_W:0]        mod_q;
  logic [MOD_W-1:0]      mod_sat;
  logic [PROD_W-1:0]     isum;
  logic [SINE_MAG_W-1:0] interp;
  logic [PROD_W-1:0]     vsum;
  logic [VOLT_W-1:0]     vmag;
  logic                  load_out;

  // Soft-start step, saturating at unity; a full ramp is left alone.
  assign ramp_sum = {1'b0, ramp_acc_r} + {1'b0, cfg.ramp_step};
  always_comb begin
    if (ramp_acc_r >= RAMP_FULL) begin
      ramp_stepped = ramp_acc_r;
    end else if (ramp_sum > {1'b0, RAMP_FULL}) begin
      ramp_stepped = RAMP_FULL;
    end else begin
      ramp_stepped = ramp_sum[RAMP_W-1:0];
    end
  end

  // Fold the lane's phase into the first quadrant.
  assign ph_sel   = ph_r[lane_r];
  assign half_mag = ph_sel[PHASE_BITS-2:0];
  assign refl     = HALF_P - {1'b0, half_mag};
  assign folded   = (half_mag > QUARTER_H) ? refl[PHASE_BITS-2:0] : half_mag;
  assign idx      = folded[PHASE_BITS-2:FRAC_BITS];

  // Rounded shifts of the registered product.
  assign msum    = prod_r + (PROD_W'(1) << (MOD_SHIFT - 1));
  assign mod_q   = msum[MOD_SHIFT +: (MOD_W + 1)];
  assign mod_sat = (mod_q > {1'b0, RAMP_FULL}) ? RAMP_FULL : mod_q[MOD_W-1:0];

  assign isum    = prod_r + (PROD_W'(1) << (FRAC_BITS - 1));
  assign interp  = isum[FRAC_BITS +: SINE_MAG_W];

  assign vsum    = prod_r + (PROD_W'(1) << (VOLT_SHIFT - 1));
  assign vmag    = vsum[VOLT_SHIFT +: VOLT_W];

  assign prod_nxt = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign load_out = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    lane_nxt      = lane_r;
    phase_acc_nxt = phase_acc_r;
    ramp_acc_nxt  = ramp_acc_r;
    out_valid_nxt = out_valid_r;
    amp_nxt       = amp_r;
    mod_nxt       = mod_r;
    ph_nxt        = ph_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    frac_nxt      = frac_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    sine_nxt      = sine_r;
    volt_nxt      = volt_r;
    out_data_nxt  = out_data_r;
    mul_a         = '0;
    mul_b         = '0;
    pop           = 1'b0;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cmd.valid) begin
          pop = 1'b1;
          if (cmd.kind == KIND_RESTART) begin
            phase_acc_nxt = '0;
            ramp_acc_nxt  = '0;
          end else begin
            ramp_acc_nxt = ramp_stepped;
            state_nxt    = ST_AMP;
          end
        end
      end
      ST_AMP: begin
        mul_a     = MUL_A_W'(ramp_acc_r);
        mul_b     = MUL_B_W'(cfg.peak_amplitude);
        ph_nxt[0] = phase_acc_r;
        ph_nxt[1] = phase_acc_r + OFF240;
        ph_nxt[2] = phase_acc_r + OFF120;
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        amp_nxt   = prod_r[MUL_A_W-1:0];
        mul_a     = MUL_A_W'(cfg.modulation_target);
        mul_b     = MUL_B_W'(ramp_acc_r);
        lane_nxt  = LANE_FIRST;
        state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        // The modulation product is still in the product register here.
        if (lane_r == LANE_FIRST) begin
          mod_nxt = mod_sat;
        end
        lo_nxt = sine_rom(idx);
        // Exactly at the quadrant edge the top entry stands alone.
        hi_nxt    = idx[SEG_BITS] ? sine_rom(idx) : sine_rom(idx + IDX_W'(1));
        frac_nxt  = folded[FRAC_BITS-1:0];
        neg_nxt   = ph_sel[PHASE_BITS-1];
        state_nxt = ST_INTP;
      end
      ST_INTP: begin
        mul_a     = MUL_A_W'(hi_r - lo_r);
        mul_b     = MUL_B_W'(frac_r);
        state_nxt = ST_SINE;
      end
      ST_SINE: begin
        mag_nxt   = lo_r + interp;
        state_nxt = ST_VOLT;
      end
      ST_VOLT: begin
        mul_a            = amp_r;
        mul_b            = MUL_B_W'(mag_r);
        sine_nxt[lane_r] = neg_r ? (SINE_W'(0) - {1'b0, mag_r}) : {1'b0, mag_r};
        state_nxt        = ST_VSTR;
      end
      ST_VSTR: begin
        volt_nxt[lane_r] = neg_r ? (VOLT_W'(0) - vmag) : vmag;
        if (lane_r == LANE_LAST) begin
          state_nxt = ST_DONE;
        end else begin
          lane_nxt  = lane_r + 2'd1;
          state_nxt = ST_LOOK;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({PHASE_NOW_W'(phase_acc_r), mod_r, ramp_acc_r,
                                        volt_r[2], volt_r[1], volt_r[0],
                                        sine_r[2], sine_r[1], sine_r[0]});
          phase_acc_nxt = phase_acc_r + cfg.phase_increment[PHASE_BITS-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lane_r      <= LANE_FIRST;
      phase_acc_r <= '0;
      ramp_acc_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lane_r      <= lane_nxt;
      phase_acc_r <= phase_acc_nxt;
      ramp_acc_r  <= ramp_acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amp_r      <= amp_nxt;
    mod_r      <= mod_nxt;
    ph_r       <= ph_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    frac_r     <= frac_nxt;
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    sine_r     <= sine_nxt;
    volt_r     <= volt_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hw/rtl/three_phase_dds_sine_soft_start_core.sv
// ----------------------------------------------------------------------------
// three_phase_dds_sine_soft_start_core: three-phase DDS sine with soft start
// Top level: configuration registers, front queue and execution sequencer.
// ----------------------------------------------------------------------------
// Each input beat is one control tick or, with bit 0 of in_tdata set, a
// restart. A tick steps the soft-start ramp (saturating at 1.0), reads three
// sines at the phase accumulator, at phase plus 240 degrees and at phase plus
// 120 degrees from a 65-entry quarter-wave table with linear interpolation,
// and returns one result beat with the unit sines, the three voltage
// commands (peak times ramp times sine, in 1/256 V), the ramp, the scaled
// modulation and the phase used; the accumulator then advances by the phase
// increment. A restart clears phase and ramp and returns nothing. A tick
// takes the command in IDLE, runs the single shared 32x24 multiplier in AMP
// and MOD, then for each of the three phases does a table lookup (LOOK),
// a multiply (INTP), a rounding (SINE), a multiply (VOLT) and a rounding
// (VSTR), and loads the result register in DONE; the multiplier is used
// eight times per tick with its product registered each time. Up to two
// input beats wait in the front queue while a tick runs, and a finished
// result waits in the output register without holding up the next tick
// until that tick itself has a result ready. Configuration writes are taken
// every cycle and are meant to arrive only while no tick is in flight.
module three_phase_dds_sine_soft_start_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input beat: tdata[0] restart, tdata[7:1] zero.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [tpdss_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Result beat, from bit 0 up: sine_u[15:0], sine_v[31:16], sine_w[47:32],
  // volt_u[64:48], volt_v[81:65], volt_w[98:82], ramp_level[115:99],
  // modulation_now[132:116], phase_now[164:133], zero fill[167:165].
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [tpdss_pkg::OUT_TDATA_W-1:0] out_tdata,
  // Register writes: 0 phase_increment, 1 peak_amplitude, 2 ramp_step,
  // 3 modulation_target.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tpdss_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tpdss_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tpdss_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  cmd_t cmd;
  logic pop;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PHASE_INC:  cfg_nxt.phase_increment   = cfg_data[31:0];
        CFG_PEAK_AMP:   cfg_nxt.peak_amplitude    = cfg_data[15:0];
        CFG_RAMP_STEP:  cfg_nxt.ramp_step         = cfg_data[RAMP_W-1:0];
        CFG_MOD_TARGET: cfg_nxt.modulation_target = cfg_data[MOD_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_increment   <= PHASE_INC_RST;
      cfg_r.peak_amplitude    <= PEAK_AMP_RST;
      cfg_r.ramp_step         <= RAMP_STEP_RST;
      cfg_r.modulation_target <= MOD_TARGET_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: accepts beats and queues them as tick or restart commands.
  tpdss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .pop       (pop),
    .cmd       (cmd)
  );

  // Back: runs one command at a time and holds the result beat.
  tpdss_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

### hw/rtl/tpdss_checker.sv
// ----------------------------------------------------------------------------
// tpdss_checker: port-level checks for the three-phase DDS sine core
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module tpdss_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tpdss_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tpdss_pkg::*;

  logic [SINE_W-1:0] sine_u;
  logic [SINE_W-1:0] sine_v;
  logic [VOLT_W-1:0] volt_u;
  logic [VOLT_W-1:0] volt_v;
  logic [VOLT_W-1:0] volt_w;
  logic [RAMP_W-1:0] ramp_level;
  logic [MOD_W-1:0]  modulation_now;

  assign sine_u         = out_tdata[15:0];
  assign sine_v         = out_tdata[31:16];
  assign volt_u         = out_tdata[64:48];
  assign volt_v         = out_tdata[81:65];
  assign volt_w         = out_tdata[98:82];
  assign ramp_level     = out_tdata[115:99];
  assign modulation_now = out_tdata[132:116];

  // Reset empties the output register.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat present right after reset");

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // The u and v voltage commands carry the sign of their sines.
  a_volt_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (volt_u == '0 || volt_u[VOLT_W-1] == sine_u[SINE_W-1]) &&
                   (volt_v == '0 || volt_v[VOLT_W-1] == sine_v[SINE_W-1]))
    else $error("voltage sign disagrees with sine sign");

  // With the ramp still at zero every scaled output is zero.
  a_zero_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ramp_level == '0 |->
      volt_u == '0 && volt_v == '0 && volt_w == '0 && modulation_now == '0)
    else $error("scaled output nonzero at zero ramp");

endmodule

bind three_phase_dds_sine_soft_start_core tpdss_checker u_checker (.*);
